@@ hw/rtl/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg: NTC conversion shared definitions
// Constants, status codes and the segment slope table for the NTC
// thermistor sample to temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int TEMP_W   = 12;
	localparam int STATUS_W = 2;

	// default walk geometry
	localparam int TABLE_SEGMENTS_DEF    = 30;
	localparam int STEPS_PER_SEGMENT_DEF = 10;

	// register reset values
	localparam logic [SAMPLE_W-1:0] OPEN_THRESHOLD_RST  = 12'd4000;
	localparam logic [SAMPLE_W-1:0] SHORT_THRESHOLD_RST = 12'd300;

	// register indexes
	localparam logic CFG_OPEN_THRESHOLD  = 1'b0;
	localparam logic CFG_SHORT_THRESHOLD = 1'b1;

	// walk constants
	localparam logic [SAMPLE_W-1:0]      START_COUNT = 12'd3923;
	localparam logic [SAMPLE_W-1:0]      END_COUNT   = 12'd342;
	localparam logic signed [TEMP_W-1:0] START_TEMP  = -12'sd405;
	localparam logic signed [TEMP_W-1:0] SAT_TEMP    = 12'sd1095;
	localparam logic signed [TEMP_W:0]   STEP_TEMP   = 13'sd5;

	// sensor status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OPEN  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

	// count drop per half-degree step, for each segment; zero past the table
	function automatic logic [4:0] seg_drop(input logic [5:0] idx);
		logic [4:0] d;
		case (idx)
			6'd0:  d = 5'd6;
			6'd1:  d = 5'd7;
			6'd2:  d = 5'd8;
			6'd3:  d = 5'd10;
			6'd4:  d = 5'd12;
			6'd5:  d = 5'd14;
			6'd6:  d = 5'd16;
			6'd7:  d = 5'd17;
			6'd8:  d = 5'd18;
			6'd9:  d = 5'd19;
			6'd10: d = 5'd20;
			6'd11: d = 5'd20;
			6'd12: d = 5'd20;
			6'd13: d = 5'd19;
			6'd14: d = 5'd18;
			6'd15: d = 5'd17;
			6'd16: d = 5'd16;
			6'd17: d = 5'd15;
			6'd18: d = 5'd13;
			6'd19: d = 5'd12;
			6'd20: d = 5'd10;
			6'd21: d = 5'd10;
			6'd22: d = 5'd8;
			6'd23: d = 5'd7;
			6'd24: d = 5'd7;
			6'd25: d = 5'd6;
			6'd26: d = 5'd5;
			6'd27: d = 5'd4;
			6'd28: d = 5'd4;
			6'd29: d = 5'd2;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

@@ hw/rtl/ntc_adc_to_temperature.sv @@
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature: NTC thermistor sample to temperature
// Piecewise-linear table walk from a 12-bit ADC reading to tenths of a
// degree C, with open and shorted sensor detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one adc_sample per request.
//   Output channel out_valid/out_ready carries temperature and
//   sensor_status, one result per sample. The temperature is 0 unless the
//   status is ok.
//   Configuration: cfg_write with cfg_index (0 open, 1 short threshold) and
//   cfg_data; the user writes only while the block is idle (unenforced).
// Timing:
//   One shared compare/subtract step runs each cycle under a two-state
//   sequencer; one half-degree step per cycle. The result register loads
//   when the walk finishes and the output register is free; for open and
//   short samples the walk finishes on its first step. in_ready is high
//   only while no sample is being walked, so the next request is taken
//   from the cycle after the result loads.
// Reset:
//   arst_n clears the sequencer and output valid and loads the thresholds
//   with 4000 (open) and 300 (short).
// Stall:
//   A finished result waits in the output register; the walk holds on its
//   final step until that register is free.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature
	import ntc_pkg::*;
#(
	parameter int TABLE_SEGMENTS    = TABLE_SEGMENTS_DEF,
	parameter int STEPS_PER_SEGMENT = STEPS_PER_SEGMENT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [SAMPLE_W-1:0]        adc_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [TEMP_W-1:0]   temperature,
	output logic [STATUS_W-1:0]        sensor_status,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [SAMPLE_W-1:0]        cfg_data
);

	localparam int SEG_W  = $clog2(TABLE_SEGMENTS + 1);
	localparam int STEP_W = $clog2(STEPS_PER_SEGMENT + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                       state_q;
	logic [SAMPLE_W-1:0]        open_thr_q;
	logic [SAMPLE_W-1:0]        short_thr_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic [STATUS_W-1:0]        status_q;
	logic [SAMPLE_W-1:0]        count_q;
	logic signed [TEMP_W-1:0]   temp_q;
	logic [SEG_W-1:0]           seg_q;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	logic signed [TEMP_W-1:0]   out_temp_q;
	logic [STATUS_W-1:0]        out_status_q;

	logic                       accept;
	logic                       slot_free;
	logic [6:0]                 seg_ext;
	logic [SAMPLE_W-1:0]        count_n;
	logic [STEP_W-1:0]          step_inc;
	logic                       seg_wrap;
	logic signed [TEMP_W:0]     temp_sum;
	logic signed [TEMP_W-1:0]   temp_n;
	logic                       finish;
	logic signed [TEMP_W-1:0]   finish_temp;

	assign in_ready      = (state_q == ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign slot_free     = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign temperature   = out_temp_q;
	assign sensor_status = out_status_q;

	// one walk step: compare, subtract the segment slope, advance step
	always_comb begin
		seg_ext  = 7'(seg_q);
		count_n  = count_q - SAMPLE_W'(seg_drop(seg_ext[5:0]));
		step_inc = step_q + 1'b1;
		seg_wrap = (step_inc >= STEP_W'(STEPS_PER_SEGMENT));
		temp_sum = $signed({temp_q[TEMP_W-1], temp_q}) + STEP_TEMP;
		// temperature held at saturation: the final clamp gives the same
		if (temp_sum > $signed({SAT_TEMP[TEMP_W-1], SAT_TEMP}))
			temp_n = SAT_TEMP;
		else
			temp_n = temp_sum[TEMP_W-1:0];

		finish      = 1'b1;
		finish_temp = SAT_TEMP;
		if (status_q != STATUS_OK) begin
			finish_temp = '0;
		end else if (sample_q > count_q) begin
			finish_temp = temp_q;
		end else if (seg_q >= SEG_W'(TABLE_SEGMENTS)) begin
			finish_temp = SAT_TEMP;
		end else if (count_n <= END_COUNT) begin
			finish_temp = SAT_TEMP;
		end else begin
			finish = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_thr_q  <= OPEN_THRESHOLD_RST;
			short_thr_q <= SHORT_THRESHOLD_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_OPEN_THRESHOLD:  open_thr_q  <= cfg_data;
				CFG_SHORT_THRESHOLD: short_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (finish && slot_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk datapath and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= adc_sample;
			count_q  <= START_COUNT;
			temp_q   <= START_TEMP;
			seg_q    <= '0;
			step_q   <= '0;
			if (adc_sample > open_thr_q)
				status_q <= STATUS_OPEN;
			else if (adc_sample < short_thr_q)
				status_q <= STATUS_SHORT;
			else
				status_q <= STATUS_OK;
		end else if (state_q == ST_WALK && !finish) begin
			count_q <= count_n;
			temp_q  <= temp_n;
			if (seg_wrap) begin
				step_q <= '0;
				seg_q  <= seg_q + 1'b1;
			end else begin
				step_q <= step_inc;
			end
		end
		if (state_q == ST_WALK && finish && slot_free) begin
			out_temp_q   <= finish_temp;
			out_status_q <= status_q;
		end
	end

endmodule
